[rtl/c3dc_pkg.sv]
`timescale 1ns / 1ps
package c3dc_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT        = 1024;
   localparam int QUEUE_DEPTH       = 4;
   localparam int PIX_W             = 8;
   localparam int POS_W             = 10;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 24;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
   localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_TOP    = 3'd0,
      CSR_COEF_MID    = 3'd1,
      CSR_COEF_BOTTOM = 3'd2,
      CSR_DIVISOR     = 3'd3,
      CSR_WIDTH       = 3'd4,
      CSR_HEIGHT      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [8:0][PIX_W-1:0] win;   // [row*3+col], row 0 = above, col 0 = left
      logic [POS_W-1:0]      row;
      logic [POS_W-1:0]      col;
      logic                  last;
   } job_type;

endpackage

[rtl/c3dc_queue.sv]
`timescale 1ns / 1ps
module c3dc_queue
   import c3dc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  job_type                        push_job,
   input  logic                           pop,
   output job_type                        head_job,
   output logic                           empty,
   output logic [$clog2(QUEUE_DEPTH):0]   count
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

   assign head_job = entry_ff[rptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

[rtl/c3dc_front.sv]
`timescale 1ns / 1ps
module c3dc_front
   import c3dc_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [PIX_W-1:0]              req_pixel_in,
   input  logic [10:0]                   frame_width,
   input  logic [10:0]                   frame_height,
   input  logic [$clog2(QUEUE_DEPTH):0]  q_count,
   output logic                          push,
   output job_type                       push_job
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [2*PIX_W-1:0] line_ff [MAX_WIDTH];   // {mid, top} per column
   logic [2*PIX_W-1:0] rd_ff;

   logic [CW-1:0]     col_ff, col_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic              a_valid_ff;
   logic [CW-1:0]     a_col_ff;
   logic [PIX_W-1:0]  a_pix_ff;
   logic              a_inner_ff;
   logic [POS_W-1:0]  a_row_out_ff;
   logic [POS_W-1:0]  a_col_out_ff;
   logic              a_last_ff;
   logic [8:0][PIX_W-1:0] win_ff, win_in;

   logic        accept;
   int unsigned w_eff, h_eff, col32, row32;
   logic        inner, last;

   assign accept    = req_valid && !req_stall;
   assign req_stall = ({1'b0, q_count} + {{($clog2(QUEUE_DEPTH)+1){1'b0}}, a_valid_ff})
                      >= ($clog2(QUEUE_DEPTH)+2)'(QUEUE_DEPTH);

   always_comb begin
      w_eff = 32'(frame_width);
      if (w_eff < 3) w_eff = 3;
      if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
      h_eff = 32'(frame_height);
      if (h_eff < 3) h_eff = 3;
      if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
      col32 = 32'(col_ff);
      row32 = 32'(row_ff);
      inner = (row32 >= 2) && (col32 >= 2);
      last  = (row32 >= h_eff - 1) && (col32 >= w_eff - 1);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col32 + 1 >= w_eff) begin
            col_in = '0;
            row_in = (row32 + 1 >= h_eff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
         win_ff     <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= accept;
         win_ff     <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff        <= line_ff[col_ff];
         a_col_ff     <= col_ff;
         a_pix_ff     <= req_pixel_in;
         a_inner_ff   <= inner;
         a_row_out_ff <= POS_W'(row32 - 1);
         a_col_out_ff <= POS_W'(col32 - 1);
         a_last_ff    <= last;
      end
      if (a_valid_ff) begin
         line_ff[a_col_ff] <= {a_pix_ff, rd_ff[2*PIX_W-1:PIX_W]};
      end
   end

   always_comb begin
      win_in = win_ff;
      if (a_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i*3]   = win_ff[i*3+1];
            win_in[i*3+1] = win_ff[i*3+2];
         end
         win_in[2] = rd_ff[PIX_W-1:0];
         win_in[5] = rd_ff[2*PIX_W-1:PIX_W];
         win_in[8] = a_pix_ff;
      end
      push          = a_valid_ff && a_inner_ff;
      push_job.win  = win_in;
      push_job.row  = a_row_out_ff;
      push_job.col  = a_col_out_ff;
      push_job.last = a_last_ff;
   end

endmodule

[rtl/c3dc_back.sv]
`timescale 1ns / 1ps
module c3dc_back
   import c3dc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  job_type                 head_job,
   input  logic                    empty,
   output logic                    pop,
   input  logic [CSR_DATA_W-1:0]   coef_top_row,
   input  logic [CSR_DATA_W-1:0]   coef_mid_row,
   input  logic [CSR_DATA_W-1:0]   coef_bottom_row,
   input  logic [6:0]              divisor_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PIX_W-1:0]        rsp_filtered_value,
   output logic [POS_W-1:0]        rsp_out_row,
   output logic [POS_W-1:0]        rsp_out_col,
   output logic                    rsp_frame_last
);

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } tag_type;

   logic advance;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   tag_type           s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [8:0][15:0]  s1_prod_ff, s1_prod_in;
   logic [15:0]       s2_acc_ff, s2_acc_in;
   logic [14:0]       s3_rem_ff, s3_rem_in;
   logic [3:0]        s3_qhi_ff, s3_qhi_in;
   logic              s3_zero_ff, s3_zero_in;
   logic              s3_sat_ff, s3_sat_in;
   logic [PIX_W-1:0]  out_value_ff, out_value_in;
   tag_type           out_tag_ff;

   logic [6:0]        div_eff;
   logic [3*CSR_DATA_W-1:0] coef_all;
   logic [14:0]       rem_a, rem_b, trial_a, trial_b;
   logic [3:0]        qlo;

   assign advance = !s4_valid_ff || !rsp_stall;
   assign pop     = advance && !empty;
   assign div_eff = (divisor_value == '0) ? 7'd1 : divisor_value;
   assign coef_all = {coef_bottom_row, coef_mid_row, coef_top_row};

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         s1_prod_in[k] = 16'($signed({1'b0, head_job.win[k]}) *
                             $signed(coef_all[k*8 +: 8]));
      end
      s2_acc_in = '0;
      for (int k = 0; k < 9; k++) begin
         s2_acc_in = s2_acc_in + s1_prod_ff[k];
      end
   end

   always_comb begin
      s3_zero_in = s2_acc_ff[15] || (s2_acc_ff == '0);
      s3_sat_in  = s2_acc_ff[14:0] >= {div_eff, 8'd0};
      rem_a      = s2_acc_ff[14:0];
      s3_qhi_in  = '0;
      trial_a    = '0;
      for (int k = 7; k >= 4; k--) begin
         trial_a = 15'(div_eff) << k;
         if (rem_a >= trial_a) begin
            rem_a = rem_a - trial_a;
            s3_qhi_in[k-4] = 1'b1;
         end
      end
      s3_rem_in = rem_a;
   end

   always_comb begin
      rem_b   = s3_rem_ff;
      qlo     = '0;
      trial_b = '0;
      for (int k = 3; k >= 0; k--) begin
         trial_b = 15'(div_eff) << k;
         if (rem_b >= trial_b) begin
            rem_b  = rem_b - trial_b;
            qlo[k] = 1'b1;
         end
      end
      if (s3_zero_ff) begin
         out_value_in = PIX_MIN;
      end else if (s3_sat_ff) begin
         out_value_in = PIX_MAX;
      end else begin
         out_value_in = {s3_qhi_ff, qlo};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= !empty;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff   <= s1_prod_in;
         s1_tag_ff    <= '{row: head_job.row, col: head_job.col, last: head_job.last};
         s2_acc_ff    <= s2_acc_in;
         s2_tag_ff    <= s1_tag_ff;
         s3_rem_ff    <= s3_rem_in;
         s3_qhi_ff    <= s3_qhi_in;
         s3_zero_ff   <= s3_zero_in;
         s3_sat_ff    <= s3_sat_in;
         s3_tag_ff    <= s2_tag_ff;
         out_value_ff <= out_value_in;
         out_tag_ff   <= s3_tag_ff;
      end
   end

   assign rsp_valid          = s4_valid_ff;
   assign rsp_filtered_value = out_value_ff;
   assign rsp_out_row        = out_tag_ff.row;
   assign rsp_out_col        = out_tag_ff.col;
   assign rsp_frame_last     = out_tag_ff.last;

endmodule

[rtl/conv3x3_divide_clamp_top.sv]
`timescale 1ns / 1ps
// 3x3 convolution with divide and clamp, one 8-bit pixel per request, raster order.
// Request channel: req_valid / req_stall / req_pixel_in; a request is taken when
// req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall with the clamped value, interior row and
// column and a frame_last flag; border pixels give no response.
// Registers are written through csr_we / csr_index / csr_wdata; the user must
// write them only while idle, which the block itself does not enforce.
// Throughput: one pixel per cycle, sustained while rsp_stall is low; the line
// buffer is read at acceptance and written back in the following cycle, and a
// 4-entry queue decouples the window from the math pipeline.
// With the queue empty, a request passes from acceptance to rsp_valid through
// window update into the queue, multiply, sum and two divide stages of four
// quotient bits each. When rsp_stall is held the math pipeline freezes, the
// queue fills and then req_stall rises; nothing is dropped.
// Reset clears position counters, window, queue and pipeline valids and restores
// register defaults; the line buffers are not cleared.
module conv3x3_divide_clamp_top
   import c3dc_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIX_W-1:0]       req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_W-1:0]       rsp_filtered_value,
   output logic [POS_W-1:0]       rsp_out_row,
   output logic [POS_W-1:0]       rsp_out_col,
   output logic                   rsp_frame_last,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CSR_DATA_W-1:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [6:0]            divisor_ff;
   logic [10:0]           width_ff, height_ff;

   logic                          push, pop, empty;
   job_type                       push_job, head_job;
   logic [$clog2(QUEUE_DEPTH):0]  q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '0;
         coef_mid_ff <= '0;
         coef_bot_ff <= '0;
         divisor_ff  <= 7'd1;
         width_ff    <= 11'd3;
         height_ff   <= 11'd3;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_TOP:    coef_top_ff <= csr_wdata;
            CSR_COEF_MID:    coef_mid_ff <= csr_wdata;
            CSR_COEF_BOTTOM: coef_bot_ff <= csr_wdata;
            CSR_DIVISOR:     divisor_ff  <= csr_wdata[6:0];
            CSR_WIDTH:       width_ff    <= csr_wdata[10:0];
            CSR_HEIGHT:      height_ff   <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   c3dc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel_in (req_pixel_in),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .q_count      (q_count),
      .push         (push),
      .push_job     (push_job)
   );

   c3dc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .count    (q_count)
   );

   c3dc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .empty              (empty),
      .pop                (pop),
      .coef_top_row       (coef_top_ff),
      .coef_mid_row       (coef_mid_ff),
      .coef_bottom_row    (coef_bot_ff),
      .divisor_value      (divisor_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_frame_last     (rsp_frame_last)
   );

endmodule
